// File: sv/dwpi_pkg.sv
`timescale 1ns / 1ps

package dwpi_pkg;

    localparam int unsigned CFG_DATA_W = 24;

    typedef logic [2:0] t_cfg_idx;

    // register indexes on the configuration channel
    localparam t_cfg_idx REG_KP            = 3'd0;
    localparam t_cfg_idx REG_KI_HALF_T     = 3'd1;
    localparam t_cfg_idx REG_NEUTRAL_WIDTH = 3'd2;
    localparam t_cfg_idx REG_PWM_MIN       = 3'd3;
    localparam t_cfg_idx REG_PWM_MAX       = 3'd4;
    localparam t_cfg_idx REG_FF_GAIN       = 3'd5;
    localparam t_cfg_idx REG_INVERT_MASK   = 3'd6;

    // action codes carried in tuser
    localparam logic ACT_UPDATE  = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // 0.082 in Q0.16 and 1/0.082 in Q4.16
    localparam logic [13:0] LIM_GAIN_Q16  = 14'd5374;
    localparam logic [19:0] TICK_GAIN_Q16 = 20'd799220;

    typedef struct packed {
        logic [15:0] kp;
        logic [23:0] ki_half_t;
        logic [14:0] neutral_width;
        logic [14:0] pwm_min;
        logic [14:0] pwm_max;
        logic [15:0] ff_gain;
        logic [1:0]  invert_mask;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INTEG,
        ST_OUT,
        ST_TICK,
        ST_DONE
    } t_state;

    // stage enables from the sequencer to both lanes
    typedef struct packed {
        logic load;
        logic mul;
        logic integ;
        logic outc;
        logic tick;
        logic clear;
    } t_lane_ctl;

endpackage

// File: sv/dwpi_lane.sv
`timescale 1ns / 1ps

module dwpi_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dwpi_pkg::t_lane_ctl i_ctl,
    input  dwpi_pkg::t_cfg      i_cfg,
    input  logic                i_invert,
    input  logic signed [15:0]  i_setpoint,
    input  logic signed [15:0]  i_speed,
    output logic [14:0]         o_pulse
);
    import dwpi_pkg::*;

    localparam logic signed [35:0] INT32_MAX_X = 36'sh07FFFFFFF;
    localparam logic signed [35:0] INT32_MIN_X = -36'sh080000000;

    logic signed [16:0] diff;
    logic signed [16:0] n_err;
    logic signed [16:0] r_err;
    logic signed [15:0] r_sp;
    logic signed [16:0] r_last_error;
    logic signed [16:0] n_last_error;
    logic signed [31:0] r_integral;
    logic signed [31:0] n_integral;

    logic signed [33:0] r_p;
    logic signed [17:0] err_sum;
    logic signed [42:0] step_prod;
    logic signed [26:0] r_step;
    logic signed [32:0] r_ff;
    logic signed [16:0] dmax;
    logic signed [16:0] dmin;
    logic signed [31:0] r_lim_max;
    logic signed [31:0] r_lim_min;

    logic signed [35:0] p_x;
    logic signed [35:0] lmax_x;
    logic signed [35:0] lmin_x;
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    logic signed [35:0] integ_raw;
    logic signed [35:0] integ_clamp;
    logic signed [31:0] integ_sat;

    logic signed [35:0] out_raw;
    logic signed [31:0] out_clamp;
    logic signed [31:0] n_out;
    logic signed [31:0] r_out;
    logic signed [52:0] tick_prod;
    logic signed [36:0] r_ticks;

    logic signed [39:0] total;
    logic signed [23:0] x_trunc;
    logic signed [23:0] pmax_x;
    logic signed [23:0] pmin_x;
    logic signed [23:0] x_hi;

    // error, reversed lanes flip the sign
    assign diff  = 17'(i_setpoint) - 17'(i_speed);
    assign n_err = i_invert ? -diff : diff;

    // products of the multiply stage
    assign err_sum   = 18'(r_err) + 18'(r_last_error);
    assign step_prod = $signed({1'b0, i_cfg.ki_half_t}) * err_sum;
    assign dmax      = $signed({2'b0, i_cfg.pwm_max}) - $signed({2'b0, i_cfg.neutral_width});
    assign dmin      = $signed({2'b0, i_cfg.pwm_min}) - $signed({2'b0, i_cfg.neutral_width});

    // integrator with limits that track the proportional term
    assign p_x    = 36'(r_p);
    assign lmax_x = 36'(r_lim_max);
    assign lmin_x = 36'(r_lim_min);

    always_comb begin
        hi        = (lmax_x > p_x) ? lmax_x - p_x : '0;
        lo        = (lmin_x < p_x) ? lmin_x - p_x : '0;
        integ_raw = 36'(r_integral) + 36'(r_step);
        if (integ_raw > hi) begin
            integ_clamp = hi;
        end else if (integ_raw < lo) begin
            integ_clamp = lo;
        end else begin
            integ_clamp = integ_raw;
        end
        if (integ_clamp > INT32_MAX_X) begin
            integ_sat = 32'sh7FFFFFFF;
        end else if (integ_clamp < INT32_MIN_X) begin
            integ_sat = 32'sh80000000;
        end else begin
            integ_sat = 32'(integ_clamp);
        end
        if (i_ctl.clear || (i_cfg.ki_half_t == '0)) begin
            n_integral = '0;
        end else begin
            n_integral = integ_sat;
        end
        n_last_error = i_ctl.clear ? '0 : r_err;
    end

    // controller output clamp, integrator is already updated here
    always_comb begin
        out_raw = p_x + 36'(r_integral);
        if (out_raw > lmax_x) begin
            out_clamp = r_lim_max;
        end else if (out_raw < lmin_x) begin
            out_clamp = r_lim_min;
        end else begin
            out_clamp = 32'(out_raw);
        end
        n_out = i_invert ? -out_clamp : out_clamp;
    end

    assign tick_prod = r_out * $signed({1'b0, TICK_GAIN_Q16});

    // pulse: neutral + feedforward + ticks, truncate toward zero, saturate
    always_comb begin
        total = 40'($signed({1'b0, i_cfg.neutral_width, 16'b0})) + 40'(r_ff) + 40'(r_ticks);
        if (total[39]) begin
            x_trunc = 24'((total + 40'sd65535) >>> 16);
        end else begin
            x_trunc = 24'(total >>> 16);
        end
        pmax_x = $signed({9'b0, i_cfg.pwm_max});
        pmin_x = $signed({9'b0, i_cfg.pwm_min});
        x_hi   = (x_trunc > pmax_x) ? pmax_x : x_trunc;
        o_pulse = (x_hi < pmin_x) ? i_cfg.pwm_min : x_hi[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral   <= '0;
            r_last_error <= '0;
        end else if (i_ctl.integ) begin
            r_integral   <= n_integral;
            r_last_error <= n_last_error;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_err <= n_err;
            r_sp  <= i_setpoint;
        end
        if (i_ctl.mul) begin
            r_p       <= $signed({1'b0, i_cfg.kp}) * r_err;
            r_step    <= 27'(step_prod >>> 16);
            r_ff      <= r_sp * $signed({1'b0, i_cfg.ff_gain});
            r_lim_max <= dmax * $signed({1'b0, LIM_GAIN_Q16});
            r_lim_min <= dmin * $signed({1'b0, LIM_GAIN_Q16});
        end
        if (i_ctl.outc) begin
            r_out <= n_out;
        end
        if (i_ctl.tick) begin
            r_ticks <= 37'(tick_prod >>> 16);
        end
    end

endmodule

// File: sv/dwpi_merge.sv
`timescale 1ns / 1ps

module dwpi_merge #(
    parameter int unsigned PWM_PERIOD = 20000
) (
    input  logic        i_timeout,
    input  logic [14:0] i_neutral,
    input  logic [14:0] i_left_pulse,
    input  logic [14:0] i_right_pulse,
    output logic [14:0] o_left_pulse,
    output logic [14:0] o_right_pulse
);
    import dwpi_pkg::*;

    localparam logic [15:0] PERIOD_W = 16'(PWM_PERIOD);

    function automatic logic [14:0] cap_period(input logic [14:0] v);
        logic [15:0] vx;
        vx = {1'b0, v};
        return (vx > PERIOD_W) ? PERIOD_W[14:0] : v;
    endfunction

    // a timeout sends neutral on both wheels
    assign o_left_pulse  = cap_period(i_timeout ? i_neutral : i_left_pulse);
    assign o_right_pulse = cap_period(i_timeout ? i_neutral : i_right_pulse);

endmodule

// File: sv/dual_wheel_pi_speed_controller.sv
`timescale 1ns / 1ps
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: setpoints and speeds, tuser: action
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: left and right pulse
// cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// one request at a time: the lanes walk a fixed chain of multiply,
// integrate, clamp, tick multiply and sum stages, one register each
// the result lands in the output register as the sequencer leaves ST_DONE
// reset (synchronous, active low) clears integrators, last errors, the sequencer
// state and the output valid, and restores the config defaults
// a stalled result waits in the output register while the next request runs;
// the last stage holds only if that register is still full
// config writes are taken only while idle with no request offered

module dual_wheel_pi_speed_controller #(
    parameter int unsigned PWM_PERIOD = 20000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // upstream requests
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] left_setpoint, [31:16] right_setpoint,
    // [47:32] left_speed, [63:48] right_speed
    input  logic [63:0]                         i_s_axis_tdata,
    // [0] action: 0 update, 1 timeout
    input  logic                                i_s_axis_tuser,
    // downstream results
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [14:0] left_pulse, [29:15] right_pulse, [31:30] zero
    output logic [31:0]                         o_m_axis_tdata,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  dwpi_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [dwpi_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dwpi_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_lane_ctl  lane_ctl;
    logic       r_action;
    logic       accept;
    logic       out_free;
    logic       out_load;
    logic       r_out_valid;
    logic [14:0] r_left_pulse;
    logic [14:0] r_right_pulse;
    logic [14:0] lane_left;
    logic [14:0] lane_right;
    logic [14:0] merge_left;
    logic [14:0] merge_right;

    // settings change only between requests, never under one in flight
    assign o_cfg_ready = (r_state == ST_IDLE) && !i_s_axis_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp            <= 16'd384;
            r_cfg.ki_half_t     <= 24'd1678;
            r_cfg.neutral_width <= 15'd1500;
            r_cfg.pwm_min       <= 15'd1000;
            r_cfg.pwm_max       <= 15'd2000;
            r_cfg.ff_gain       <= 16'd20480;
            r_cfg.invert_mask   <= 2'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KP:            r_cfg.kp            <= i_cfg_data[15:0];
                REG_KI_HALF_T:     r_cfg.ki_half_t     <= i_cfg_data[23:0];
                REG_NEUTRAL_WIDTH: r_cfg.neutral_width <= i_cfg_data[14:0];
                REG_PWM_MIN:       r_cfg.pwm_min       <= i_cfg_data[14:0];
                REG_PWM_MAX:       r_cfg.pwm_max       <= i_cfg_data[14:0];
                REG_FF_GAIN:       r_cfg.ff_gain       <= i_cfg_data[15:0];
                REG_INVERT_MASK:   r_cfg.invert_mask   <= i_cfg_data[1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // sequencer: one request in flight
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_INTEG;
            ST_INTEG: n_state = ST_OUT;
            ST_OUT:   n_state = ST_TICK;
            ST_TICK:  n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        lane_ctl.load   = (r_state == ST_IDLE) && i_s_axis_tvalid;
        lane_ctl.mul    = (r_state == ST_MUL);
        lane_ctl.integ  = (r_state == ST_INTEG);
        lane_ctl.outc   = (r_state == ST_OUT);
        lane_ctl.tick   = (r_state == ST_TICK);
        lane_ctl.clear  = r_action;
        out_load        = (r_state == ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_s_axis_tuser;
        end
    end

    // left lane sees setpoint/speed in the low half words, right lane the upper
    dwpi_lane u_lane_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_cfg      (r_cfg),
        .i_invert   (r_cfg.invert_mask[0]),
        .i_setpoint ($signed(i_s_axis_tdata[15:0])),
        .i_speed    ($signed(i_s_axis_tdata[47:32])),
        .o_pulse    (lane_left)
    );

    dwpi_lane u_lane_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lane_ctl),
        .i_cfg      (r_cfg),
        .i_invert   (r_cfg.invert_mask[1]),
        .i_setpoint ($signed(i_s_axis_tdata[31:16])),
        .i_speed    ($signed(i_s_axis_tdata[63:48])),
        .o_pulse    (lane_right)
    );

    // timeout select and period cap for both wheels
    dwpi_merge #(
        .PWM_PERIOD (PWM_PERIOD)
    ) u_merge (
        .i_timeout     (r_action),
        .i_neutral     (r_cfg.neutral_width),
        .i_left_pulse  (lane_left),
        .i_right_pulse (lane_right),
        .o_left_pulse  (merge_left),
        .o_right_pulse (merge_right)
    );

    // output register, parts the sequencer from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_left_pulse  <= merge_left;
            r_right_pulse <= merge_right;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b0, r_right_pulse, r_left_pulse};

    // an accepted request always enters the multiply stage next
    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_MUL))
        else $error("accepted request did not start the lane stages");

    // finishing a request fills the output register and frees the input
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("finished request not handed to the output register");

    // the last stage never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !out_load)
        else $error("waiting result overwritten");

    // at most one lane stage is enabled at a time
    a_one_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({lane_ctl.load, lane_ctl.mul, lane_ctl.integ, lane_ctl.outc,
                  lane_ctl.tick}))
        else $error("more than one lane stage enabled");

endmodule

// File: bench/dwpi_pulse_checker.sv
`timescale 1ns / 1ps

module dwpi_pulse_checker #(
    parameter int unsigned PWM_PERIOD = 20000
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    input  logic [63:0]                     i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [31:0]                     i_m_axis_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  dwpi_pkg::t_cfg_idx              i_cfg_index,
    input  logic [dwpi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_done,
    output int                              o_pending,
    output int                              o_fail_count
);
    import dwpi_pkg::*;

    localparam longint LIM_GAIN  = longint'(LIM_GAIN_Q16);
    localparam longint TICK_GAIN = longint'(TICK_GAIN_Q16);

    typedef struct packed {
        logic [14:0] left;
        logic [14:0] right;
    } t_pulse_pair;

    t_pulse_pair              pulse_q[$];
    t_cfg                     cfg_sh;
    logic signed [31:0]       lane_integ [2];
    logic signed [16:0]       lane_err_prev [2];
    int                       fail_cnt;
    int                       pending_n;
    logic                     leftovers_done;
    t_pulse_pair              got;
    t_pulse_pair              want;
    logic [14:0]              stop_pulse;

    assign o_pending    = pending_n;
    assign o_fail_count = fail_cnt;

    initial begin
        fail_cnt       = 0;
        pending_n      = 0;
        leftovers_done = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // one wheel: error, pi terms, clamps, then back to pulse ticks
    function automatic logic [14:0] predict_lane(input int ln,
                                                 input logic signed [15:0] sp,
                                                 input logic signed [15:0] meas);
        longint err, p, lim_hi, lim_lo, room_up, room_dn, integ, ctl, total, ticks;
        logic   rev;
        rev    = cfg_sh.invert_mask[ln];
        err    = longint'(sp) - longint'(meas);
        if (rev)
            err = -err;
        lim_hi = (longint'(cfg_sh.pwm_max) - longint'(cfg_sh.neutral_width)) * LIM_GAIN;
        lim_lo = (longint'(cfg_sh.pwm_min) - longint'(cfg_sh.neutral_width)) * LIM_GAIN;
        p      = longint'(cfg_sh.kp) * err;

        if (cfg_sh.ki_half_t == 0) begin
            integ = 0;
        end else begin
            room_up = (lim_hi > p) ? lim_hi - p : 0;
            room_dn = (lim_lo < p) ? lim_lo - p : 0;
            integ   = longint'(lane_integ[ln])
                    + ((longint'(cfg_sh.ki_half_t) * (err + longint'(lane_err_prev[ln])))
                       >>> 16);
            if (integ > room_up)
                integ = room_up;
            else if (integ < room_dn)
                integ = room_dn;
            if (integ > 64'sd2147483647)
                integ = 64'sd2147483647;
            if (integ < -64'sd2147483648)
                integ = -64'sd2147483648;
        end
        lane_integ[ln]    = 32'(integ);
        lane_err_prev[ln] = 17'(err);

        ctl = p + integ;
        if (ctl > lim_hi)
            ctl = lim_hi;
        else if (ctl < lim_lo)
            ctl = lim_lo;
        if (rev)
            ctl = -ctl;

        total = longint'(cfg_sh.neutral_width) * 65536
              + longint'(sp) * longint'(cfg_sh.ff_gain)
              + ((ctl * TICK_GAIN) >>> 16);
        // truncate toward zero
        ticks = (total >= 0) ? (total >>> 16) : -((-total) >>> 16);

        if (ticks > longint'(cfg_sh.pwm_max))
            ticks = longint'(cfg_sh.pwm_max);
        if (ticks < longint'(cfg_sh.pwm_min))
            ticks = longint'(cfg_sh.pwm_min);
        if (ticks > longint'(PWM_PERIOD))
            ticks = longint'(PWM_PERIOD);
        return 15'(ticks);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_sh.kp            = 16'd384;
            cfg_sh.ki_half_t     = 24'd1678;
            cfg_sh.neutral_width = 15'd1500;
            cfg_sh.pwm_min       = 15'd1000;
            cfg_sh.pwm_max       = 15'd2000;
            cfg_sh.ff_gain       = 16'd20480;
            cfg_sh.invert_mask   = 2'd2;
            lane_integ[0]        = '0;
            lane_integ[1]        = '0;
            lane_err_prev[0]     = '0;
            lane_err_prev[1]     = '0;
            pulse_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KP:            cfg_sh.kp            = i_cfg_data[15:0];
                    REG_KI_HALF_T:     cfg_sh.ki_half_t     = i_cfg_data[23:0];
                    REG_NEUTRAL_WIDTH: cfg_sh.neutral_width = i_cfg_data[14:0];
                    REG_PWM_MIN:       cfg_sh.pwm_min       = i_cfg_data[14:0];
                    REG_PWM_MAX:       cfg_sh.pwm_max       = i_cfg_data[14:0];
                    REG_FF_GAIN:       cfg_sh.ff_gain       = i_cfg_data[15:0];
                    REG_INVERT_MASK:   cfg_sh.invert_mask   = i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.left  = i_m_axis_tdata[14:0];
                got.right = i_m_axis_tdata[29:15];
                if (pulse_q.size() == 0) begin
                    report_mismatch($sformatf("result 0x%08h with no request pending",
                                              i_m_axis_tdata));
                end else begin
                    want = pulse_q.pop_front();
                    if (got.left !== want.left)
                        report_mismatch($sformatf("left_pulse got %0d expected %0d",
                                                  got.left, want.left));
                    if (got.right !== want.right)
                        report_mismatch($sformatf("right_pulse got %0d expected %0d",
                                                  got.right, want.right));
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (i_s_axis_tuser == ACT_TIMEOUT) begin
                    lane_integ[0]    = '0;
                    lane_integ[1]    = '0;
                    lane_err_prev[0] = '0;
                    lane_err_prev[1] = '0;
                    stop_pulse = (cfg_sh.neutral_width > PWM_PERIOD) ? 15'(PWM_PERIOD)
                                                                     : cfg_sh.neutral_width;
                    want.left  = stop_pulse;
                    want.right = stop_pulse;
                end else begin
                    want.left  = predict_lane(0, i_s_axis_tdata[15:0], i_s_axis_tdata[47:32]);
                    want.right = predict_lane(1, i_s_axis_tdata[31:16], i_s_axis_tdata[63:48]);
                end
                pulse_q.push_back(want);
            end

            if (i_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                while (pulse_q.size() != 0) begin
                    want = pulse_q.pop_front();
                    report_mismatch($sformatf("result never arrived (left %0d right %0d)",
                                              want.left, want.right));
                end
            end
        end
        pending_n = pulse_q.size();
    end

endmodule

// File: bench/tb_dual_wheel_pi_speed_controller.sv
`timescale 1ns / 1ps

module tb_dual_wheel_pi_speed_controller;

    import dwpi_pkg::*;

    localparam int unsigned PULSE_FRAME = 20000;
    localparam int STALL_LIMIT     = 2000;   // cycles with no transfer on any channel
    localparam int SETTLE_CYCLES   = 24;     // wait after the block has gone idle, before the final check
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 128;

    // index with no register behind it, the block must ignore the write
    localparam t_cfg_idx REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [63:0]           s_data;
    logic                  s_user;
    logic                  m_valid;
    logic                  m_ready;
    logic [31:0]           m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  done_flag;
    int                    pending_cnt;
    int                    fail_cnt;

    // random back-pressure and sender gaps are switched off for the final phase
    logic                  calm;
    int                    stall_left;
    int                    quiet_cycles;

    // state of the current setpoint-tracking run
    int                    trk_left_sp;
    int                    trk_right_sp;
    int                    trk_run;
    int                    trk_noise;

    dual_wheel_pi_speed_controller #(
        .PWM_PERIOD      (PULSE_FRAME)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // predicts every request and compares the pulses coming back
    dwpi_pulse_checker #(
        .PWM_PERIOD      (PULSE_FRAME)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_done          (done_flag),
        .o_pending       (pending_cnt),
        .o_fail_count    (fail_cnt)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // downstream back-pressure: random stall bursts, with ready raised again
    // between bursts so results always drain
    always @(negedge clk) begin
        if (!calm && stall_left == 0 && m_ready && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 16);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: ends the run if nothing moves on any channel for too long
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_cnt);
            $display("** dual_wheel_pi_speed_controller: FAILED **");
            $finish;
        end
    end

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    // one request on the input stream, with an optional random gap before it;
    // valid stays high across back-to-back requests
    task automatic send_req(input logic act, input logic [15:0] l_sp, input logic [15:0] r_sp,
                            input logic [15:0] l_spd, input logic [15:0] r_spd);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= {r_spd, l_spd, r_sp, l_sp};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    // drop valid and hold off until every expected pulse pair has come back
    task automatic wait_idle();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_cnt != 0)
            @(negedge clk);
    endtask

    // valid is left high so consecutive writes go back to back
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input int kp, input int ki, input int neutral, input int lo,
                               input int hi, input int ff, input int inv);
        write_reg(REG_KP,            CFG_DATA_W'(kp));
        write_reg(REG_KI_HALF_T,     CFG_DATA_W'(ki));
        write_reg(REG_NEUTRAL_WIDTH, CFG_DATA_W'(neutral));
        write_reg(REG_PWM_MIN,       CFG_DATA_W'(lo));
        write_reg(REG_PWM_MAX,       CFG_DATA_W'(hi));
        write_reg(REG_FF_GAIN,       CFG_DATA_W'(ff));
        write_reg(REG_INVERT_MASK,   CFG_DATA_W'(inv));
        end_writes();
    endtask

    // mostly steady setpoint runs with the measured speed hovering near the
    // target, so the integrator actually builds up; the rest is noise,
    // extremes and timeouts
    task automatic send_random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            send_req(ACT_TIMEOUT, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            trk_run = 0;
        end else if (roll < 18) begin
            send_req(ACT_UPDATE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (roll < 26) begin
            send_req(ACT_UPDATE, pick_extreme(), pick_extreme(), pick_extreme(),
                     pick_extreme());
        end else begin
            if (trk_run == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    trk_left_sp  = rand_signed(32767);
                    trk_right_sp = rand_signed(32767);
                end else begin
                    trk_left_sp  = rand_signed($urandom_range(16, 2048));
                    trk_right_sp = rand_signed($urandom_range(16, 2048));
                end
                trk_noise = ($urandom_range(0, 3) == 0) ? 1024 : $urandom_range(0, 48);
                trk_run   = $urandom_range(4, 40);
            end
            trk_run--;
            send_req(ACT_UPDATE, sat16(trk_left_sp), sat16(trk_right_sp),
                     sat16(trk_left_sp + rand_signed(trk_noise)),
                     sat16(trk_right_sp + rand_signed(trk_noise)));
        end
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        s_user       = ACT_UPDATE;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_KP;
        cfg_data     = '0;
        done_flag    = 1'b0;
        calm         = 1'b0;
        stall_left   = 0;
        quiet_cycles = 0;
        trk_run      = 0;
        trk_noise    = 0;
        trk_left_sp  = 0;
        trk_right_sp = 0;

        // hold the synchronous reset, then release it
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero request, then a step held for three requests so
        // the integrator accumulates (right lane is reversed at reset)
        send_req(ACT_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        // largest errors of both signs
        send_req(ACT_UPDATE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_req(ACT_UPDATE, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_req(ACT_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // timeout clears both lanes, data is ignored
        send_req(ACT_TIMEOUT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(ACT_UPDATE, 16'h0200, 16'h0200, 16'h0100, 16'h0100);
        // zero error but extreme setpoints: feedforward pushes into saturation
        send_req(ACT_UPDATE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);

        // integral disabled, plus a write to an unused index that must be ignored
        wait_idle();
        write_reg(REG_KI_HALF_T, '0);
        write_reg(REG_UNUSED, '1);
        end_writes();
        send_req(ACT_UPDATE, 16'h0300, 16'hFD00, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'h0300, 16'hFD00, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'hF000, 16'h1000, 16'h0800, 16'hF800);

        // pwm_min above pwm_max: upper output clamp first, then min wins on the pulse
        wait_idle();
        load_config(384, 1678, 1500, 1800, 1200, 20480, 1);
        send_req(ACT_UPDATE, 16'h0400, 16'hFC00, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'hFC00, 16'h0400, 16'h0000, 16'h0000);
        send_req(ACT_TIMEOUT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // largest gains, both lanes reversed
        wait_idle();
        load_config(65535, 16777215, 10000, 0, 20000, 65535, 3);
        send_req(ACT_UPDATE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_req(ACT_UPDATE, 16'h0010, 16'hFFF0, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'h0010, 16'hFFF0, 16'h0000, 16'h0000);
        send_req(ACT_UPDATE, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_req(ACT_TIMEOUT, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_idle();
            case (ph)
                // near the reset values
                0: load_config($urandom_range(0, 1024), $urandom_range(1, 20000), 1500,
                               1000, 2000, $urandom_range(0, 25600), $urandom_range(0, 3));
                // everything at the bottom of its range
                1: load_config(0, 0, 0, 0, 0, 0, 0);
                // top kp and ki gains with wide pulse limits
                2: load_config(65535, 16777215, 20000, 0, 20000, $urandom_range(0, 256), 3);
                // limits pinned at the top
                3: load_config($urandom_range(0, 65535), $urandom_range(0, 4096), 20000,
                               20000, 20000, 65535, $urandom_range(0, 3));
                // crossed pulse limits
                4: load_config($urandom_range(0, 2048), $urandom_range(0, 65535), 1500,
                               $urandom_range(1500, 2500), $urandom_range(500, 1500),
                               $urandom_range(0, 25600), $urandom_range(0, 3));
                default: begin
                    if (ph == PHASE_COUNT - 1)
                        calm = 1'b1;
                    load_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 2048),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16777215)
                                                            : $urandom_range(0, 65535),
                                $urandom_range(0, 20000), $urandom_range(0, 20000),
                                $urandom_range(0, 20000),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 8192),
                                $urandom_range(0, 3));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // one mid-phase hold-off until everything has come back
                if (ph == 2 && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                send_random_item();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        done_flag <= 1'b1;
        repeat (2) @(negedge clk);

        if (fail_cnt == 0) begin
            $display("** dual_wheel_pi_speed_controller: PASSED **");
        end else begin
            $display("** dual_wheel_pi_speed_controller: FAILED **");
        end
        $finish;
    end

endmodule
